// ----- rtl/rlb_pkg.sv -----
// rlb_pkg: types, constants and helper functions for the rgba layer blender
// used by the config register block, the datapath and the top level
package rlb_pkg;

  localparam int unsigned AddrW = 3;
  localparam int unsigned DataW = 32;

  localparam logic [16:0] FullOpacity = 17'd65536;
  localparam logic [23:0] Den         = 24'd16711680;
  localparam logic [23:0] HalfDen     = 24'd8355840;
  localparam logic [17:0] SatLimit    = 18'd65280;

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_SCREEN = 2'd1,
    MODE_ADD    = 2'd2
  } blend_mode_e;

  typedef enum logic {
    REG_MODE    = 1'b0,
    REG_OPACITY = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [7:0] src_red;
    logic [7:0] src_green;
    logic [7:0] src_blue;
    logic [7:0] src_alpha;
    logic [7:0] dst_red;
    logic [7:0] dst_green;
    logic [7:0] dst_blue;
    logic [7:0] dst_alpha;
  } pixel_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;
  } result_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [16:0] opacity;
  } cfg_t;

  // floor(x / 255), exact for x below 65280
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] t;
    t = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
    return t[15:8];
  endfunction

  function automatic logic [7:0] sat8(input logic [8:0] x);
    return x[8] ? 8'd255 : x[7:0];
  endfunction

endpackage

// ----- rtl/rgba_layer_blender.sv -----
// rgba_layer_blender: top level, apb config registers and blend pipeline
// depends on rlb_pkg, rlb_cfg and rlb_datapath
//
// Blends one premultiplied rgba source pixel over one destination pixel per
// transfer in normal, screen or saturating add mode. The pipeline takes one
// pixel every clock while it is not stalled and passes it through three
// register stages (opacity multiply, weighted mix, rounding and divide by
// 255). Each stage holds its item while the next one is full and cannot
// advance, so a stalled output only stalls the input once all stages are
// occupied. Write blend_mode at byte 0 and opacity at byte 4 while no pixel
// is in flight.
module rgba_layer_blender
  import rlb_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  input  pixel_t           pixel_i,
  input  logic             pixel_valid_i,
  output logic             pixel_stall_o,
  output result_t          result_o,
  output logic             result_valid_o,
  input  logic             result_stall_i
);

  cfg_t cfg;

  rlb_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  rlb_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .pixel_i        (pixel_i),
    .pixel_valid_i  (pixel_valid_i),
    .pixel_stall_o  (pixel_stall_o),
    .result_o       (result_o),
    .result_valid_o (result_valid_o),
    .result_stall_i (result_stall_i)
  );

endmodule

// ----- rtl/rlb_cfg.sv -----
// rlb_cfg: apb register file holding blend mode and opacity
// depends on rlb_pkg
module rlb_cfg
  import rlb_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  output cfg_t             cfg_o
);

  logic [1:0]  mode_q;
  logic [16:0] opacity_q;
  logic        wr_en;
  reg_idx_e    idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_NORMAL;
      opacity_q <= FullOpacity;
    end else if (wr_en) begin
      case (idx)
        REG_MODE:    mode_q    <= pwdata[1:0];
        REG_OPACITY: opacity_q <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_MODE:    prdata = {30'd0, mode_q};
      REG_OPACITY: prdata = {15'd0, opacity_q};
      default:     prdata = '0;
    endcase
  end

  assign cfg_o.mode    = mode_q;
  assign cfg_o.opacity = opacity_q;

endmodule

// ----- rtl/rlb_datapath.sv -----
// rlb_datapath: three-stage blend pipeline with per-stage valid and stall
// depends on rlb_pkg
module rlb_datapath
  import rlb_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  input  pixel_t  pixel_i,
  input  logic    pixel_valid_i,
  output logic    pixel_stall_o,
  output result_t result_o,
  output logic    result_valid_o,
  input  logic    result_stall_i
);

  logic v1_q, v2_q, v3_q;
  logic en1, en2, en3;

  assign en3 = !v3_q || !result_stall_i;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign pixel_stall_o = !en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= pixel_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  // stage 1: opacity products, screen products, sums
  logic [7:0]  s_in [4];
  logic [7:0]  d_in [4];
  logic [16:0] opa;

  blend_mode_e mode1_q;
  logic [7:0]  s1_q   [4];
  logic [7:0]  d1_q   [4];
  logic [23:0] p1_q   [4];
  logic [15:0] sd1_q  [4];
  logic [8:0]  sum1_q [4];

  always_comb begin
    s_in[0] = pixel_i.src_red;
    s_in[1] = pixel_i.src_green;
    s_in[2] = pixel_i.src_blue;
    s_in[3] = pixel_i.src_alpha;
    d_in[0] = pixel_i.dst_red;
    d_in[1] = pixel_i.dst_green;
    d_in[2] = pixel_i.dst_blue;
    d_in[3] = pixel_i.dst_alpha;
    opa = (cfg_i.opacity > FullOpacity) ? FullOpacity : cfg_i.opacity;
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      mode1_q <= blend_mode_e'(cfg_i.mode);
      for (int i = 0; i < 4; i++) begin
        logic [24:0] prod;
        prod      = {17'd0, s_in[i]} * {8'd0, opa};
        s1_q[i]   <= s_in[i];
        d1_q[i]   <= d_in[i];
        p1_q[i]   <= prod[23:0];
        sd1_q[i]  <= {8'd0, s_in[i]} * {8'd0, d_in[i]};
        sum1_q[i] <= {1'b0, s_in[i]} + {1'b0, d_in[i]};
      end
    end
  end

  // stage 2: weighted numerators, screen quotient
  logic [23:0] w;
  assign w = Den - p1_q[3];

  blend_mode_e mode2_q;
  logic        zero2_q, full2_q;
  logic [7:0]  s2_q   [4];
  logic [7:0]  d2_q   [4];
  logic [32:0] num2_q [4];
  logic [7:0]  scr2_q [4];
  logic [8:0]  sum2_q [4];

  always_ff @(posedge clk_i) begin
    if (en2) begin
      mode2_q <= mode1_q;
      zero2_q <= (p1_q[3] == 24'd0);
      full2_q <= (p1_q[3] >= Den);
      for (int i = 0; i < 4; i++) begin
        logic [31:0] dw;
        logic [31:0] p255;
        dw         = {24'd0, d1_q[i]} * {8'd0, w};
        p255       = {p1_q[i], 8'd0} - {8'd0, p1_q[i]};
        s2_q[i]    <= s1_q[i];
        d2_q[i]    <= d1_q[i];
        num2_q[i]  <= {1'b0, dw} + {1'b0, p255};
        scr2_q[i]  <= div255(sd1_q[i]);
        sum2_q[i]  <= sum1_q[i];
      end
    end
  end

  // stage 3: rounding, division by 255, mode select
  logic [7:0] res3 [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      logic [33:0] rnd;
      logic [17:0] q1;
      logic [7:0]  norm;
      logic [8:0]  scr;
      rnd  = {1'b0, num2_q[i]} + {10'd0, HalfDen};
      q1   = rnd[33:16];
      norm = (q1 >= SatLimit) ? 8'd255 : div255(q1[15:0]);
      scr  = {1'b0, s2_q[i]} + {1'b0, d2_q[i]} - {1'b0, scr2_q[i]};
      case (mode2_q)
        MODE_SCREEN: res3[i] = sat8(scr);
        MODE_ADD:    res3[i] = sat8(sum2_q[i]);
        default: begin
          if (zero2_q)      res3[i] = d2_q[i];
          else if (full2_q) res3[i] = s2_q[i];
          else              res3[i] = norm;
        end
      endcase
    end
  end

  result_t out_q;

  always_ff @(posedge clk_i) begin
    if (en3) begin
      out_q.out_red   <= res3[0];
      out_q.out_green <= res3[1];
      out_q.out_blue  <= res3[2];
      out_q.out_alpha <= res3[3];
    end
  end

  assign result_o       = out_q;
  assign result_valid_o = v3_q;

  a_out_from_s2 : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(v3_q) |-> $past(v2_q))
    else $error("output valid without a stage 2 item");

  a_s2_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q && v3_q && result_stall_i |=> v2_q && $stable(num2_q[0]) && $stable(zero2_q))
    else $error("stage 2 item lost under stall");

  a_stall_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pixel_stall_o |-> v1_q && v2_q && v3_q && result_stall_i)
    else $error("input stalled with a bubble in the pipeline");

  a_s1_to_s2 : assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q && en2 |=> v2_q)
    else $error("stage 1 item dropped");

endmodule

// ----- sim/rgba_layer_blender_tb.sv -----
// rgba_layer_blender_tb: self-checking testbench for the rgba layer blender,
// a queue-fed pixel driver, a result monitor and an own blend predictor
// depends on rlb_pkg and rgba_layer_blender
module rgba_layer_blender_tb
  import rlb_pkg::*;
();

  localparam logic [1:0] ModeUnused = 2'd3;
  localparam int unsigned PhaseCount = 11;
  localparam int unsigned PhasePixels = 175;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned WatchdogLimit = 5000;
  localparam int unsigned DrainCycles = 10;

  logic             clk = 1'b0;
  logic             rst_ni = 1'b0;
  logic             psel = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [DataW-1:0] pwdata = '0;
  logic [DataW-1:0] prdata;
  logic             pready;
  pixel_t           pixel = '0;
  logic             pixel_valid = 1'b0;
  logic             pixel_stall;
  result_t          result;
  logic             result_valid;
  logic             result_stall = 1'b0;

  pixel_t      pixel_backlog[$];
  result_t     pending_blends[$];
  result_t     want;
  logic [1:0]  cfg_mode = MODE_NORMAL;
  logic [16:0] cfg_opacity = FullOpacity;
  bit          in_taken = 1'b0;
  bit          steady = 1'b0;
  bit          hold_req = 1'b0;
  bit          hold_done = 1'b0;
  int unsigned hold_left = 0;
  int unsigned quiet_cycles = 0;
  int unsigned mismatches = 0;

  rgba_layer_blender DUT (
    .clk_i          (clk),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .pixel_i        (pixel),
    .pixel_valid_i  (pixel_valid),
    .pixel_stall_o  (pixel_stall),
    .result_o       (result),
    .result_valid_o (result_valid),
    .result_stall_i (result_stall)
  );

  always #5 clk = ~clk;

  function automatic logic [7:0] clamp_chan(input longint unsigned v);
    return (v > 255) ? 8'd255 : v[7:0];
  endfunction

  function automatic result_t blend_pixel(input pixel_t px, input logic [1:0] mode,
                                          input logic [16:0] opac);
    longint unsigned s[4];
    longint unsigned d[4];
    logic [7:0]      r[4];
    longint unsigned o, a, w, span, sum, prod;
    result_t         res;
    s = '{px.src_red, px.src_green, px.src_blue, px.src_alpha};
    d = '{px.dst_red, px.dst_green, px.dst_blue, px.dst_alpha};
    span = Den;
    case (mode)
      MODE_SCREEN: begin
        for (int k = 0; k < 4; k++) begin
          sum = s[k] + d[k];
          prod = (s[k] * d[k]) / 255;
          r[k] = clamp_chan((sum >= prod) ? sum - prod : 0);
        end
      end
      MODE_ADD: begin
        for (int k = 0; k < 4; k++) r[k] = clamp_chan(s[k] + d[k]);
      end
      default: begin
        // normal over, unused code included; opacity saturates at one
        o = (opac > FullOpacity) ? FullOpacity : opac;
        a = s[3] * o;
        if (a == 0) begin
          for (int k = 0; k < 4; k++) r[k] = d[k][7:0];
        end else if (a >= span) begin
          for (int k = 0; k < 4; k++) r[k] = s[k][7:0];
        end else begin
          w = span - a;
          for (int k = 0; k < 3; k++)
            r[k] = clamp_chan((d[k] * w + 255 * s[k] * o + span / 2) / span);
          r[3] = clamp_chan((d[3] * w + 255 * a + span / 2) / span);
        end
      end
    endcase
    res.out_red   = r[0];
    res.out_green = r[1];
    res.out_blue  = r[2];
    res.out_alpha = r[3];
    return res;
  endfunction

  function automatic pixel_t random_pixel();
    pixel_t      px;
    logic [63:0] raw;
    int unsigned roll, sa, da;
    roll = $urandom_range(99);
    px = {$urandom, $urandom};
    if (roll < 70) begin
      // well-formed premultiplied data, alpha extremes now and then
      if ($urandom_range(9) == 0) sa = $urandom_range(1) ? 255 : 0;
      else sa = $urandom_range(255);
      da = $urandom_range(255);
      px.src_alpha = 8'(sa);
      px.src_red   = 8'($urandom_range(sa));
      px.src_green = 8'($urandom_range(sa));
      px.src_blue  = 8'($urandom_range(sa));
      px.dst_alpha = 8'(da);
      px.dst_red   = 8'($urandom_range(da));
      px.dst_green = 8'($urandom_range(da));
      px.dst_blue  = 8'($urandom_range(da));
    end else if (roll >= 85) begin
      raw = px;
      for (int k = 0; k < 8; k++) begin
        case ($urandom_range(2))
          0: raw[k*8 +: 8] = 8'h00;
          1: raw[k*8 +: 8] = 8'hFF;
          default: raw[k*8 +: 8] = 8'($urandom);
        endcase
      end
      px = raw;
    end
    return px;
  endfunction

  task automatic write_reg(input reg_idx_e idx, input logic [31:0] value);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = AddrW'({idx, 2'b00});
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    if (idx == REG_MODE) cfg_mode = value[1:0];
    else cfg_opacity = value[16:0];
  endtask

  task automatic drain();
    while (pixel_backlog.size() != 0 || pixel_valid || pending_blends.size() != 0)
      @(negedge clk);
  endtask

  task automatic check_chan(input string name, input logic [7:0] exp, input logic [7:0] act);
    if (exp !== act) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp, act);
      mismatches++;
    end
  endtask

  // pixel driver
  always @(negedge clk) begin
    if (rst_ni && (!pixel_valid || in_taken)) begin
      if (pixel_backlog.size() != 0 && (steady || $urandom_range(99) >= 25)) begin
        pixel <= pixel_backlog.pop_front();
        pixel_valid <= 1'b1;
      end else begin
        pixel_valid <= 1'b0;
      end
    end
  end

  // result receiver, with one long hold-off
  always @(negedge clk) begin
    if (hold_left != 0) begin
      result_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      result_stall <= 1'b1;
      hold_left <= HoldCycles;
      hold_done <= 1'b1;
    end else begin
      result_stall <= !steady && ($urandom_range(99) < 25);
    end
  end

  // transfer monitor and watchdog
  always @(posedge clk) begin
    in_taken <= rst_ni && pixel_valid && !pixel_stall;
    if (rst_ni && pixel_valid && !pixel_stall)
      pending_blends.push_back(blend_pixel(pixel, cfg_mode, cfg_opacity));
    if (rst_ni && result_valid && !result_stall) begin
      if (pending_blends.size() == 0) begin
        $error("result transfer with no pending blend: %h", result);
        mismatches++;
      end else begin
        want = pending_blends.pop_front();
        check_chan("out_red", want.out_red, result.out_red);
        check_chan("out_green", want.out_green, result.out_green);
        check_chan("out_blue", want.out_blue, result.out_blue);
        check_chan("out_alpha", want.out_alpha, result.out_alpha);
      end
    end
    if ((pixel_valid && !pixel_stall) || (result_valid && !result_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    pixel_t      probes[8];
    logic [1:0]  probe_modes[3];
    logic [1:0]  modes[PhaseCount];
    logic [16:0] levels[PhaseCount];
    probes = '{
      pixel_t'(64'h00000000_00000000),
      pixel_t'(64'hFFFFFFFF_FFFFFFFF),
      pixel_t'(64'hC8643200_10203040),
      pixel_t'(64'hFF8001FF_AA55CC33),
      pixel_t'(64'h40302080_FFFFFFFF),
      pixel_t'(64'hFFFFFF01_0080FF7F),
      pixel_t'(64'hAAAAAAAA_55555555),
      pixel_t'(64'h55555555_AAAAAAAA)
    };
    probe_modes = '{MODE_NORMAL, MODE_SCREEN, MODE_ADD};
    modes = '{MODE_NORMAL, MODE_NORMAL, MODE_NORMAL, MODE_NORMAL, MODE_NORMAL,
              MODE_NORMAL, MODE_SCREEN, MODE_ADD, ModeUnused, MODE_NORMAL, MODE_SCREEN};
    levels = '{FullOpacity, 17'd0, 17'd1, 17'd65535, 17'h1FFFF, 17'd32768,
               17'd12345, 17'd0, 17'd40000, 17'($urandom_range(65536)), 17'h1FFFF};

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_ni = 1'b1;

    // directed probes under each mode at reset opacity
    foreach (probe_modes[m]) begin
      write_reg(REG_MODE, 32'(probe_modes[m]));
      foreach (probes[k]) pixel_backlog.push_back(probes[k]);
      drain();
    end

    for (int p = 0; p < PhaseCount; p++) begin
      write_reg(REG_MODE, 32'(modes[p]));
      write_reg(REG_OPACITY, 32'(levels[p]));
      steady = (p == 5);
      if (p == 3) hold_req = 1'b1;
      repeat (PhasePixels) pixel_backlog.push_back(random_pixel());
      drain();
    end
    steady = 1'b0;

    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/rlb_pkg.sv
rtl/rlb_cfg.sv
rtl/rlb_datapath.sv
rtl/rgba_layer_blender.sv
sim/rgba_layer_blender_tb.sv
